@@ sv/urc_pkg.sv @@
// Shared types, codes and constants for the ultrasonic ranging controller.
`timescale 1ns / 1ps

package urc_pkg;

    // Field widths fixed by the interface.
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 3;
    localparam int REFUSED_W  = 2;
    localparam int PULSE_W    = 16;
    localparam int TIMEOUT_W  = 24;
    localparam int ECHO_W     = 24;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 1;

    // Default counter width.
    localparam int COUNT_WIDTH_DEF = 24;

    // Register reset values.
    localparam logic [PULSE_W-1:0]   PULSE_RST   = PULSE_W'(10);
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = TIMEOUT_W'(100000);

    // Largest reportable echo width.
    localparam logic [ECHO_W-1:0] ECHO_MAX = {ECHO_W{1'b1}};

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b1;

    // Command codes.
    localparam logic [OP_W-1:0] OP_NONE  = 2'd0;
    localparam logic [OP_W-1:0] OP_START = 2'd1;
    localparam logic [OP_W-1:0] OP_RESET = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_NOT_STARTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_IN_PROGRESS = 3'd1;
    localparam logic [STATUS_W-1:0] ST_SUCCESS     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TIMED_OUT   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN     = 3'd4;

    // Refusal codes.
    localparam logic [REFUSED_W-1:0] REF_NONE  = 2'd0;
    localparam logic [REFUSED_W-1:0] REF_BUSY  = 2'd1;
    localparam logic [REFUSED_W-1:0] REF_WRONG = 2'd2;

    // Measurement phase.
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PULSE,
        PH_WAIT,
        PH_MEASURE,
        PH_DONE,
        PH_TIMEOUT,
        PH_UNKNOWN
    } t_phase;

    // One result item.
    typedef struct packed {
        logic                 trigger_level;
        logic [STATUS_W-1:0]  status;
        logic [ECHO_W-1:0]    echo_ticks;
        logic [REFUSED_W-1:0] refused;
    } t_result;

endpackage

@@ sv/urc_core.sv @@
// Measurement sequencer: configuration registers, phase, counters and result logic.
`timescale 1ns / 1ps

module urc_core #(
    parameter int COUNT_WIDTH = urc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [urc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [urc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_step,
    input  logic [urc_pkg::OP_W-1:0]       i_op,
    input  logic                           i_echo_level,
    output urc_pkg::t_result               o_result
);

    // Compare width wide enough for counters and register values alike.
    localparam int CW_MAX = (COUNT_WIDTH > urc_pkg::TIMEOUT_W) ? COUNT_WIDTH
                                                               : urc_pkg::TIMEOUT_W;
    localparam logic [CW_MAX-1:0] CNT_MAX = CW_MAX'({COUNT_WIDTH{1'b1}});

    logic [urc_pkg::PULSE_W-1:0]   r_pulse_ticks;
    logic [urc_pkg::TIMEOUT_W-1:0] r_timeout_ticks;
    urc_pkg::t_phase               r_phase, n_phase;
    logic [COUNT_WIDTH-1:0]        r_tick, n_tick;
    logic [COUNT_WIDTH-1:0]        r_width, n_width;
    logic                          r_prev_echo;

    urc_pkg::t_phase               cmd_phase;
    logic [urc_pkg::REFUSED_W-1:0] refused;
    logic                          echo_edge;
    logic                          running;
    logic [CW_MAX-1:0]             pulse_raw, timeout_raw;
    logic [CW_MAX-1:0]             pulse_lim, timeout_lim;
    logic [CW_MAX-1:0]             width_ext;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_ticks   <= urc_pkg::PULSE_RST;
            r_timeout_ticks <= urc_pkg::TIMEOUT_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == urc_pkg::CFG_PULSE) begin
                r_pulse_ticks <= i_cfg_data[urc_pkg::PULSE_W-1:0];
            end else begin
                r_timeout_ticks <= i_cfg_data[urc_pkg::TIMEOUT_W-1:0];
            end
        end
    end

    // Limits: a zero register acts as one, and a limit never exceeds the counter maximum.
    always_comb begin
        pulse_raw   = (r_pulse_ticks == '0) ? CW_MAX'(1) : CW_MAX'(r_pulse_ticks);
        timeout_raw = (r_timeout_ticks == '0) ? CW_MAX'(1) : CW_MAX'(r_timeout_ticks);
        pulse_lim   = (pulse_raw > CNT_MAX) ? CNT_MAX : pulse_raw;
        timeout_lim = (timeout_raw > CNT_MAX) ? CNT_MAX : timeout_raw;
    end

    assign echo_edge = (i_echo_level != r_prev_echo);
    assign running   = (r_phase == urc_pkg::PH_PULSE) || (r_phase == urc_pkg::PH_WAIT) ||
                       (r_phase == urc_pkg::PH_MEASURE);

    // Next state: the command is applied first, then one step of the phase.
    always_comb begin
        n_phase = r_phase;
        n_tick  = r_tick;
        n_width = r_width;
        refused = urc_pkg::REF_NONE;

        case (i_op)
            urc_pkg::OP_START: begin
                if (r_phase == urc_pkg::PH_IDLE) begin
                    n_phase = urc_pkg::PH_PULSE;
                    n_tick  = '0;
                    n_width = '0;
                end else if (running) begin
                    refused = urc_pkg::REF_BUSY;
                end else begin
                    refused = urc_pkg::REF_WRONG;
                end
            end
            urc_pkg::OP_RESET: begin
                if (running) begin
                    refused = urc_pkg::REF_BUSY;
                end else begin
                    n_phase = urc_pkg::PH_IDLE;
                    n_tick  = '0;
                    n_width = '0;
                end
            end
            default: begin
            end
        endcase

        cmd_phase = n_phase;

        case (cmd_phase)
            urc_pkg::PH_PULSE: begin
                if (echo_edge) begin
                    n_phase = urc_pkg::PH_UNKNOWN;
                end else begin
                    n_tick = (n_tick == '1) ? n_tick : n_tick + COUNT_WIDTH'(1);
                    if (CW_MAX'(n_tick) >= pulse_lim) begin
                        n_phase = urc_pkg::PH_WAIT;
                        n_tick  = '0;
                    end
                end
            end
            urc_pkg::PH_WAIT: begin
                if (echo_edge) begin
                    n_phase = urc_pkg::PH_MEASURE;
                    n_width = '0;
                end else begin
                    n_tick = (n_tick == '1) ? n_tick : n_tick + COUNT_WIDTH'(1);
                    if (CW_MAX'(n_tick) >= timeout_lim) begin
                        n_phase = urc_pkg::PH_TIMEOUT;
                    end
                end
            end
            urc_pkg::PH_MEASURE: begin
                n_width = (n_width == '1) ? n_width : n_width + COUNT_WIDTH'(1);
                if (echo_edge) begin
                    n_phase = urc_pkg::PH_DONE;
                end
            end
            default: begin
            end
        endcase
    end

    // Result of this tick, taken from the phase after the command and the final phase.
    always_comb begin
        width_ext              = CW_MAX'(n_width);
        o_result.trigger_level = (cmd_phase == urc_pkg::PH_PULSE);
        o_result.refused       = refused;
        o_result.echo_ticks    = '0;
        case (n_phase)
            urc_pkg::PH_IDLE:    o_result.status = urc_pkg::ST_NOT_STARTED;
            urc_pkg::PH_DONE:    o_result.status = urc_pkg::ST_SUCCESS;
            urc_pkg::PH_TIMEOUT: o_result.status = urc_pkg::ST_TIMED_OUT;
            urc_pkg::PH_UNKNOWN: o_result.status = urc_pkg::ST_UNKNOWN;
            default:             o_result.status = urc_pkg::ST_IN_PROGRESS;
        endcase
        if (n_phase == urc_pkg::PH_DONE) begin
            if (width_ext > CW_MAX'(urc_pkg::ECHO_MAX)) begin
                o_result.echo_ticks = urc_pkg::ECHO_MAX;
            end else begin
                o_result.echo_ticks = width_ext[urc_pkg::ECHO_W-1:0];
            end
        end
    end

    // State registers advance once per accepted tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= urc_pkg::PH_IDLE;
            r_tick      <= '0;
            r_width     <= '0;
            r_prev_echo <= 1'b0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_tick      <= n_tick;
            r_width     <= n_width;
            r_prev_echo <= i_echo_level;
        end
    end

endmodule

@@ sv/urc_skid.sv @@
// Output register with a skid stage, so a request is taken while a result waits.
`timescale 1ns / 1ps

module urc_skid (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  urc_pkg::t_result i_data,
    output logic             o_full,
    output logic             o_valid,
    output urc_pkg::t_result o_data,
    input  logic             i_stall
);

    logic             r_out_valid;
    logic             r_skid_valid;
    urc_pkg::t_result r_out;
    urc_pkg::t_result r_skid;
    logic             out_free;

    assign out_free = !r_out_valid || !i_stall;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;
    assign o_full   = r_skid_valid;

    // Control: the skid stage fills only when the output register is held.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || i_push;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (i_push) begin
                r_out <= i_data;
            end
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

endmodule

@@ sv/ultrasonic_ranging_controller_unit.sv @@
// Top level of the ultrasonic ranging controller.
`timescale 1ns / 1ps

// Each request is one time tick carrying an optional command and the sampled
// echo level, and gives exactly one result. A request is taken in every clock
// cycle while the output side keeps up: the tick's whole step is combinational
// between the phase and counter registers and the output register, and
// a two-entry output stage (output register plus skid) lets the next request
// in while a result waits. The input stalls only when both output entries are
// held. Configuration is written through a plain write port and should change
// only while idle.

module ultrasonic_ranging_controller_unit #(
    parameter int COUNT_WIDTH = urc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [urc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [urc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [urc_pkg::OP_W-1:0]       i_op,
    input  logic                           i_echo_level,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_trigger_level,
    output logic [urc_pkg::STATUS_W-1:0]   o_status,
    output logic [urc_pkg::ECHO_W-1:0]     o_echo_ticks,
    output logic [urc_pkg::REFUSED_W-1:0]  o_refused
);

    logic             skid_full;
    logic             step;
    urc_pkg::t_result step_result;
    urc_pkg::t_result out_result;

    assign o_stall = skid_full;
    assign step    = i_valid && !skid_full;

    urc_core #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_step      (step),
        .i_op        (i_op),
        .i_echo_level(i_echo_level),
        .o_result    (step_result)
    );

    urc_skid u_skid (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (step),
        .i_data (step_result),
        .o_full (skid_full),
        .o_valid(o_valid),
        .o_data (out_result),
        .i_stall(i_stall)
    );

    // Result fields.
    assign o_trigger_level = out_result.trigger_level;
    assign o_status        = out_result.status;
    assign o_echo_ticks    = out_result.echo_ticks;
    assign o_refused       = out_result.refused;

endmodule

@@ sv/urc_checker.sv @@
// Port-level checks for the ultrasonic ranging controller, bound to the top level.
`timescale 1ns / 1ps

module urc_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_stall,
    input logic                           o_valid,
    input logic                           i_stall,
    input logic                           o_trigger_level,
    input logic [urc_pkg::STATUS_W-1:0]   o_status,
    input logic [urc_pkg::ECHO_W-1:0]     o_echo_ticks,
    input logic [urc_pkg::REFUSED_W-1:0]  o_refused
);

    // The input side is stalled only while a result is already waiting.
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result pending");

    // A stalled result stays offered.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("stalled result withdrawn");

    // A width is reported only with success.
    a_width_only_success: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != urc_pkg::ST_SUCCESS)) |-> (o_echo_ticks == '0))
        else $error("echo width reported without success");

    // A pulse tick ends either still running or as unknown.
    a_trigger_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_trigger_level) |->
            ((o_status == urc_pkg::ST_IN_PROGRESS) || (o_status == urc_pkg::ST_UNKNOWN)))
        else $error("trigger high with a finished or idle status");

    // A start refused for wrong state leaves a finished run in place.
    a_wrong_state_finished: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_refused == urc_pkg::REF_WRONG)) |->
            ((o_status == urc_pkg::ST_SUCCESS) || (o_status == urc_pkg::ST_TIMED_OUT) ||
             (o_status == urc_pkg::ST_UNKNOWN)))
        else $error("wrong-state refusal without a finished run");

endmodule

bind ultrasonic_ranging_controller_unit urc_checker u_urc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_trigger_level(o_trigger_level),
    .o_status       (o_status),
    .o_echo_ticks   (o_echo_ticks),
    .o_refused      (o_refused)
);

@@ tb/ultrasonic_ranging_controller_unit_tb.sv @@
// Self-checking testbench for the ultrasonic ranging controller: directed ticks, then random runs.
`timescale 1ns / 1ps

module ultrasonic_ranging_controller_unit_tb;

    localparam int COUNT_W       = urc_pkg::COUNT_WIDTH_DEF;
    localparam int OP_BITS       = urc_pkg::OP_W;
    localparam int PULSE_BITS    = urc_pkg::PULSE_W;
    localparam int TIMEOUT_BITS  = urc_pkg::TIMEOUT_W;
    localparam int ECHO_BITS     = urc_pkg::ECHO_W;
    localparam int CFG_DATA_BITS = urc_pkg::CFG_DATA_W;
    localparam int CFG_IDX_BITS  = urc_pkg::CFG_IDX_W;
    localparam logic [31:0] CNT_MAX = (32'd1 << COUNT_W) - 32'd1;
    // Op code 3 is unused and behaves as no command.
    localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;
    localparam int PHASE_TICKS = 135;

    // Tracks the controller state per accepted tick and holds the expected results.
    class tick_scoreboard;
        urc_pkg::t_phase           cur_phase;
        logic [COUNT_W-1:0]        tick_cnt;
        logic [COUNT_W-1:0]        width_cnt;
        logic                      prev_echo;
        logic [PULSE_BITS-1:0]     pulse_reg;
        logic [TIMEOUT_BITS-1:0]   timeout_reg;
        urc_pkg::t_result          expected_q[$];
        int                        errors;
        int                        n_checked;

        function new();
            cur_phase   = urc_pkg::PH_IDLE;
            tick_cnt    = '0;
            width_cnt   = '0;
            prev_echo   = 1'b0;
            pulse_reg   = urc_pkg::PULSE_RST;
            timeout_reg = urc_pkg::TIMEOUT_RST;
            errors      = 0;
            n_checked   = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            if (idx == urc_pkg::CFG_PULSE) begin
                pulse_reg = data[PULSE_BITS-1:0];
            end else begin
                timeout_reg = data[TIMEOUT_BITS-1:0];
            end
        endfunction

        // A register value of zero acts as one; the counter width caps it.
        function logic [COUNT_W-1:0] limit_of(logic [31:0] r);
            if (r == 32'd0) r = 32'd1;
            if (r > CNT_MAX) r = CNT_MAX;
            return r[COUNT_W-1:0];
        endfunction

        function int pulse_limit();
            return int'(limit_of(32'(pulse_reg)));
        endfunction

        function int timeout_limit();
            return int'(limit_of(32'(timeout_reg)));
        endfunction

        function logic [COUNT_W-1:0] bump(logic [COUNT_W-1:0] v);
            return (v == '1) ? v : v + COUNT_W'(1);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Works out the result of one accepted request and queues it.
        function void note_request(logic [OP_BITS-1:0] op, logic echo);
            urc_pkg::t_result r;
            logic             echo_flip;
            logic             running;
            echo_flip = (echo != prev_echo);
            running = (cur_phase == urc_pkg::PH_PULSE) || (cur_phase == urc_pkg::PH_WAIT) ||
                      (cur_phase == urc_pkg::PH_MEASURE);
            r = '0;
            r.refused = urc_pkg::REF_NONE;

            // Command handling comes first.
            if (op == urc_pkg::OP_START) begin
                if (cur_phase == urc_pkg::PH_IDLE) begin
                    cur_phase = urc_pkg::PH_PULSE;
                    tick_cnt  = '0;
                    width_cnt = '0;
                end else if (running) begin
                    r.refused = urc_pkg::REF_BUSY;
                end else begin
                    r.refused = urc_pkg::REF_WRONG;
                end
            end else if (op == urc_pkg::OP_RESET) begin
                if (running) begin
                    r.refused = urc_pkg::REF_BUSY;
                end else begin
                    cur_phase = urc_pkg::PH_IDLE;
                    tick_cnt  = '0;
                    width_cnt = '0;
                end
            end

            r.trigger_level = (cur_phase == urc_pkg::PH_PULSE);

            // Phase step for this tick.
            case (cur_phase)
                urc_pkg::PH_PULSE: begin
                    if (echo_flip) begin
                        cur_phase = urc_pkg::PH_UNKNOWN;
                    end else begin
                        tick_cnt = bump(tick_cnt);
                        if (tick_cnt >= limit_of(32'(pulse_reg))) begin
                            cur_phase = urc_pkg::PH_WAIT;
                            tick_cnt  = '0;
                        end
                    end
                end
                urc_pkg::PH_WAIT: begin
                    if (echo_flip) begin
                        cur_phase = urc_pkg::PH_MEASURE;
                        width_cnt = '0;
                    end else begin
                        tick_cnt = bump(tick_cnt);
                        if (tick_cnt >= limit_of(32'(timeout_reg)))
                            cur_phase = urc_pkg::PH_TIMEOUT;
                    end
                end
                urc_pkg::PH_MEASURE: begin
                    width_cnt = bump(width_cnt);
                    if (echo_flip) cur_phase = urc_pkg::PH_DONE;
                end
                default: ;
            endcase

            prev_echo = echo;

            case (cur_phase)
                urc_pkg::PH_IDLE:    r.status = urc_pkg::ST_NOT_STARTED;
                urc_pkg::PH_DONE:    r.status = urc_pkg::ST_SUCCESS;
                urc_pkg::PH_TIMEOUT: r.status = urc_pkg::ST_TIMED_OUT;
                urc_pkg::PH_UNKNOWN: r.status = urc_pkg::ST_UNKNOWN;
                default:             r.status = urc_pkg::ST_IN_PROGRESS;
            endcase
            if (cur_phase == urc_pkg::PH_DONE) r.echo_ticks = ECHO_BITS'(width_cnt);
            expected_q.push_back(r);
        endfunction

        task report(string what);
            errors++;
            $display("%0t ns: result %0d: %s", $time, n_checked, what);
        endtask

        // Compares a delivered result with the oldest expectation.
        task check_result(urc_pkg::t_result got);
            urc_pkg::t_result want;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result, status %0d echo_ticks %0d",
                                 got.status, got.echo_ticks));
                return;
            end
            want = expected_q.pop_front();
            if (got.trigger_level !== want.trigger_level)
                report($sformatf("trigger_level %b, want %b", got.trigger_level,
                                 want.trigger_level));
            if (got.status !== want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.echo_ticks !== want.echo_ticks)
                report($sformatf("echo_ticks %0d, want %0d", got.echo_ticks,
                                 want.echo_ticks));
            if (got.refused !== want.refused)
                report($sformatf("refused %0d, want %0d", got.refused, want.refused));
            n_checked++;
        endtask
    endclass

    logic                               clk = 1'b0;
    logic                               rst_n;
    logic                               cfg_we;
    logic [CFG_IDX_BITS-1:0]            cfg_idx;
    logic [CFG_DATA_BITS-1:0]           cfg_data;
    logic                               tx_valid;
    logic [OP_BITS-1:0]                 tx_op;
    logic                               tx_echo;
    logic                               dut_stall;
    logic                               res_valid;
    logic                               rx_stall;
    logic                               res_trigger;
    logic [urc_pkg::STATUS_W-1:0]       res_status;
    logic [ECHO_BITS-1:0]               res_ticks;
    logic [urc_pkg::REFUSED_W-1:0]      res_refused;

    tick_scoreboard sb;
    bit             no_idle;
    logic           line_level;
    int             n_sent;

    ultrasonic_ranging_controller_unit i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_valid         (tx_valid),
        .o_stall         (dut_stall),
        .i_op            (tx_op),
        .i_echo_level    (tx_echo),
        .o_valid         (res_valid),
        .i_stall         (rx_stall),
        .o_trigger_level (res_trigger),
        .o_status        (res_status),
        .o_echo_ticks    (res_ticks),
        .o_refused       (res_refused)
    );

    always #10 clk = ~clk;

    // Results are checked before the request of the same edge is noted.
    always @(posedge clk) begin
        urc_pkg::t_result got;
        if (rst_n === 1'b1) begin
            if (res_valid === 1'b1 && rx_stall == 1'b0) begin
                got.trigger_level = res_trigger;
                got.status        = res_status;
                got.echo_ticks    = res_ticks;
                got.refused       = res_refused;
                sb.check_result(got);
            end
            if (tx_valid && dut_stall === 1'b0) sb.note_request(tx_op, tx_echo);
        end
    end

    // Result side: a random stall before each result, none while no_idle is set.
    initial begin
        int n;
        forever begin
            n = no_idle ? 0 : $urandom_range(0, 9);
            if (n > 0) begin
                rx_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            rx_stall <= 1'b0;
            @(posedge clk);
            while (res_valid !== 1'b1) @(posedge clk);
        end
    end

    // Sends one tick request after a random gap and waits until it is taken.
    task automatic send_tick(input logic [OP_BITS-1:0] op, input logic echo);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            tx_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tx_valid <= 1'b1;
        tx_op    <= op;
        tx_echo  <= echo;
        @(posedge clk);
        while (dut_stall !== 1'b0) @(posedge clk);
        n_sent++;
    endtask

    // Stops requesting and lets every outstanding result arrive.
    task automatic drain();
        tx_valid <= 1'b0;
        // One edge first, so the last accepted request is already noted.
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic load_config(input logic [PULSE_BITS-1:0] pulse,
                               input logic [TIMEOUT_BITS-1:0] tmo);
        cfg_we   <= 1'b1;
        cfg_idx  <= urc_pkg::CFG_PULSE;
        cfg_data <= CFG_DATA_BITS'(pulse);
        @(posedge clk);
        cfg_idx  <= urc_pkg::CFG_TIMEOUT;
        cfg_data <= CFG_DATA_BITS'(tmo);
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(urc_pkg::CFG_PULSE, CFG_DATA_BITS'(pulse));
        sb.set_reg(urc_pkg::CFG_TIMEOUT, CFG_DATA_BITS'(tmo));
    endtask

    // Mostly no command; now and then a start or reset, which a running run refuses, or the unused code.
    function automatic logic [OP_BITS-1:0] noise_op();
        case ($urandom_range(0, 15))
            0:       return urc_pkg::OP_START;
            1:       return urc_pkg::OP_RESET;
            2:       return OP_UNUSED;
            default: return urc_pkg::OP_NONE;
        endcase
    endfunction

    // One measurement: optional reset, start, pulse, wait for the first edge, measure to the second.
    task automatic run_measurement();
        int plen;
        int tmo;
        int wait_len;
        int width_len;
        int k;
        plen = sb.pulse_limit();
        tmo  = sb.timeout_limit();
        if ($urandom_range(0, 3) != 0) send_tick(urc_pkg::OP_RESET, line_level);
        // An edge on the accept tick or within the pulse ends the run as unknown.
        if (plen < 100 && $urandom_range(0, 11) == 0) line_level = ~line_level;
        send_tick(urc_pkg::OP_START, line_level);
        for (k = 1; k < plen; k++) begin
            if (plen < 100 && $urandom_range(0, 39) == 0) line_level = ~line_level;
            send_tick(noise_op(), line_level);
        end
        // A wait longer than the timeout gives a timed-out run.
        wait_len = $urandom_range(0, (tmo < 38) ? tmo + 2 : 40);
        for (k = 0; k < wait_len; k++) send_tick(noise_op(), line_level);
        line_level = ~line_level;
        send_tick(noise_op(), line_level);
        width_len = $urandom_range(0, 24);
        for (k = 0; k < width_len; k++) send_tick(noise_op(), line_level);
        line_level = ~line_level;
        send_tick(noise_op(), line_level);
        // A little noise after the run, commands and echo alike.
        repeat ($urandom_range(0, 3)) begin
            line_level = 1'($urandom_range(0, 1));
            send_tick(OP_BITS'($urandom_range(0, 3)), line_level);
        end
    endtask

    initial begin
        int k;
        int first;
        sb = new();
        no_idle    = 1'b0;
        n_sent     = 0;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_idx   <= urc_pkg::CFG_PULSE;
        cfg_data  <= '0;
        tx_valid  <= 1'b0;
        tx_op     <= urc_pkg::OP_NONE;
        tx_echo   <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed ticks; zero in both registers acts as one.
        load_config(16'd0, 24'd0);
        send_tick(urc_pkg::OP_NONE, 1'b1);    // echo moving outside a run is ignored
        send_tick(OP_UNUSED, 1'b1);
        send_tick(urc_pkg::OP_RESET, 1'b1);   // reset while idle
        send_tick(urc_pkg::OP_START, 1'b0);   // edge on the accept tick: unknown
        send_tick(urc_pkg::OP_START, 1'b0);   // start after a finished run: wrong state
        send_tick(urc_pkg::OP_RESET, 1'b0);
        send_tick(urc_pkg::OP_START, 1'b0);
        send_tick(urc_pkg::OP_NONE, 1'b0);    // no edge: timed out
        send_tick(urc_pkg::OP_RESET, 1'b0);
        send_tick(urc_pkg::OP_START, 1'b0);
        send_tick(urc_pkg::OP_NONE, 1'b1);    // edge on the timeout tick wins
        send_tick(urc_pkg::OP_START, 1'b1);   // start during a run: busy
        send_tick(urc_pkg::OP_RESET, 1'b1);   // reset during a run: busy
        send_tick(OP_UNUSED, 1'b0);           // second edge: success
        send_tick(urc_pkg::OP_START, 1'b0);
        send_tick(urc_pkg::OP_RESET, 1'b0);
        drain();
        load_config(16'd3, 24'd1);
        send_tick(urc_pkg::OP_START, 1'b0);
        send_tick(urc_pkg::OP_NONE, 1'b1);    // edge in the middle of the pulse
        send_tick(urc_pkg::OP_RESET, 1'b1);
        line_level = 1'b1;

        // Random runs under several register settings.
        for (k = 0; k < 6; k++) begin
            drain();
            case (k)
                0: load_config(16'd1, 24'd1);
                1: load_config(16'd2, 24'd6);
                2: load_config(16'd4, 24'd25);
                3: load_config(urc_pkg::PULSE_RST, urc_pkg::TIMEOUT_RST);
                4: load_config(PULSE_BITS'($urandom_range(1, 12)),
                               TIMEOUT_BITS'($urandom_range(1, 40)));
                default: load_config(16'd3, 24'd12);
            endcase
            first = n_sent;
            while (n_sent - first < PHASE_TICKS) begin
                no_idle = ($urandom_range(0, 4) == 0);
                run_measurement();
            end
        end

        // The largest register values: a short stretch of pulse, then an edge in it.
        drain();
        load_config(16'hFFFF, 24'hFFFFFF);
        no_idle = 1'b1;
        send_tick(urc_pkg::OP_START, line_level);
        repeat (20) send_tick(urc_pkg::OP_NONE, line_level);
        line_level = ~line_level;
        send_tick(urc_pkg::OP_NONE, line_level);
        send_tick(urc_pkg::OP_RESET, line_level);
        no_idle = 1'b0;
        drain();

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #(20_000_000);
        $display("FAILURE");
        $finish;
    end

endmodule

@@ ultrasonic_ranging_controller_unit.f @@
sv/urc_pkg.sv
sv/urc_core.sv
sv/urc_skid.sv
sv/ultrasonic_ranging_controller_unit.sv
sv/urc_checker.sv
tb/ultrasonic_ranging_controller_unit_tb.sv
